### hw/rtl/ssg_pkg.sv
// Shared types and constants for the square spiral scan generator.
package ssg_pkg;

  // Widths of internal quantities
  localparam int unsigned POS_W   = 9;   // two's complement grid position
  localparam int unsigned SIDE_W  = 8;   // effective side, up to 127
  localparam int unsigned SQ_W    = 2 * SIDE_W;
  localparam int unsigned LEG_W   = 8;
  localparam int unsigned CELLS_W = 13;
  localparam int unsigned MOVES_W = 15;
  localparam int unsigned CFG_W   = 7;

  localparam logic [LEG_W-1:0]   LEG_MAX   = '1;
  localparam logic [CELLS_W-1:0] CELLS_MAX = '1;
  localparam logic [MOVES_W-1:0] MOVES_MAX = '1;

  // Operation codes
  localparam logic OP_START   = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  // Leg directions in spiral order
  typedef enum logic [1:0] {
    DIR_COL_INC = 2'd0,
    DIR_ROW_INC = 2'd1,
    DIR_COL_DEC = 2'd2,
    DIR_ROW_DEC = 2'd3
  } dir_e;

  typedef struct packed {
    logic       operation;
    logic [5:0] start_row;
    logic [5:0] start_col;
  } ssg_in_t;

  typedef struct packed {
    logic                cell_valid;
    logic [CELLS_W-1:0]  cell_number;
    logic [MOVES_W-1:0]  moves_total;
    logic                scan_done;
  } ssg_out_t;

endpackage

### hw/rtl/ssg_walker.sv
// Spiral walk state and the combinational step/visit logic.
module ssg_walker import ssg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  ssg_in_t           item_i,
  input  logic [SIDE_W-1:0] side_i,
  input  logic [SQ_W-1:0]   side_sq_i,
  output ssg_out_t          result_o
);

  logic [POS_W-1:0]   row_q, row_d, col_q, col_d;
  logic [LEG_W-1:0]   len_q, len_d, prog_q, prog_d, prog_inc;
  dir_e               dir_q, dir_d;
  logic [CELLS_W-1:0] cells_q, cells_d;
  logic [MOVES_W-1:0] moves_q, moves_d;
  logic               fin_q, fin_d;

  logic                  in_grid;
  logic [CELLS_W-1:0]    index;
  logic                  do_visit;

  // Compute the next walk state and the result for this item
  always_comb begin
    row_d    = row_q;
    col_d    = col_q;
    len_d    = len_q;
    prog_d   = prog_q;
    dir_d    = dir_q;
    cells_d  = cells_q;
    moves_d  = moves_q;
    fin_d    = fin_q;
    do_visit = 1'b0;
    prog_inc = prog_q + LEG_W'(1);

    if (item_i.operation == OP_START) begin
      row_d    = POS_W'(item_i.start_row);
      col_d    = POS_W'(item_i.start_col);
      len_d    = LEG_W'(1);
      prog_d   = '0;
      dir_d    = DIR_COL_INC;
      cells_d  = '0;
      moves_d  = MOVES_W'(1);
      fin_d    = 1'b0;
      do_visit = 1'b1;
    end else if (!fin_q) begin
      // advance one step along the current leg
      case (dir_q)
        DIR_COL_INC: col_d = col_q + POS_W'(1);
        DIR_ROW_INC: row_d = row_q + POS_W'(1);
        DIR_COL_DEC: col_d = col_q - POS_W'(1);
        default:     row_d = row_q - POS_W'(1);
      endcase
      if (moves_q != MOVES_MAX) moves_d = moves_q + MOVES_W'(1);
      do_visit = 1'b1;
      // turn at the end of a leg, lengthen after every second leg
      if (prog_inc >= len_q) begin
        prog_d = '0;
        if (dir_q[0] && len_q != LEG_MAX) len_d = len_q + LEG_W'(1);
        dir_d = dir_e'(dir_q + 2'd1);
      end else begin
        prog_d = prog_inc;
      end
    end

    // bounds check and row-major index of the new position
    in_grid = !row_d[POS_W-1] && !col_d[POS_W-1]
              && (row_d < POS_W'(side_i)) && (col_d < POS_W'(side_i));
    index   = CELLS_W'(row_d[SIDE_W-2:0]) * CELLS_W'(side_i)
              + CELLS_W'(col_d[SIDE_W-2:0]) + CELLS_W'(1);

    result_o.cell_valid  = do_visit && in_grid;
    result_o.cell_number = result_o.cell_valid ? index : '0;
    if (result_o.cell_valid) begin
      if (cells_d != CELLS_MAX) cells_d = cells_d + CELLS_W'(1);
      if (SQ_W'(cells_d) >= side_sq_i) fin_d = 1'b1;
    end
    result_o.moves_total = moves_d;
    result_o.scan_done   = fin_d;
  end

  // Hold the walk state, advance on each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      len_q   <= LEG_W'(1);
      prog_q  <= '0;
      dir_q   <= DIR_COL_INC;
      cells_q <= '0;
      moves_q <= MOVES_W'(1);
      fin_q   <= 1'b0;
    end else if (step_en_i) begin
      row_q   <= row_d;
      col_q   <= col_d;
      len_q   <= len_d;
      prog_q  <= prog_d;
      dir_q   <= dir_d;
      cells_q <= cells_d;
      moves_q <= moves_d;
      fin_q   <= fin_d;
    end
  end

endmodule

### hw/rtl/square_spiral_scan_generator_core.sv
// Top level of the square spiral scan generator.
//
// Each input item (start or advance) yields one result item. An item is held
// in the input register while the walker steps the spiral and computes the
// cell number (one small multiply), then in the result register. One item
// per cycle is sustained as long as results are taken. The side register
// (and its square, used for the done check) is loaded from cfg_wdata_i
// whenever cfg_we_i is high; values of 0 act as 1 and values above MAX_SIDE
// act as MAX_SIDE.
module square_spiral_scan_generator_core import ssg_pkg::*; #(
  parameter int unsigned MAX_SIDE = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ssg_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ssg_out_t         out_data_o
);

  localparam logic [SIDE_W-1:0] MaxSide = SIDE_W'(MAX_SIDE);

  logic [SIDE_W-1:0] side_q, side_d;
  logic [SQ_W-1:0]   side_sq_q;
  logic              s1_valid_q;
  ssg_in_t           s1_data_q;
  logic              s1_move;
  logic              in_fire;
  ssg_out_t          result;
  logic              out_valid_q;
  ssg_out_t          out_data_q;

  // Clamp the written side into the supported range
  always_comb begin
    side_d = SIDE_W'(cfg_wdata_i);
    if (cfg_wdata_i == '0)   side_d = SIDE_W'(1);
    else if (side_d > MaxSide) side_d = MaxSide;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q    <= SIDE_W'(1);
      side_sq_q <= SQ_W'(1);
    end else if (cfg_we_i) begin
      side_q    <= side_d;
      side_sq_q <= SQ_W'(side_d) * SQ_W'(side_d);
    end
  end

  // Handshake between the input register and the result register
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire || (s1_valid_q && !s1_move);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) s1_data_q <= in_data_i;
  end

  ssg_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (s1_move),
    .item_i    (s1_data_q),
    .side_i    (side_q),
    .side_sq_i (side_sq_q),
    .result_o  (result)
  );

  // Hold the result until the transfer completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= s1_move || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) out_data_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks on the datapath and the stage handoff
  a_cell_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cell_valid |-> out_data_o.cell_number != '0)
    else $error("valid cell reported with number zero");

  a_cell_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.cell_valid |-> out_data_o.cell_number == '0)
    else $error("invalid cell reported with nonzero number");

  a_moves_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.moves_total != '0)
    else $error("move total is zero");

  a_stage_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_o)
    else $error("item left input register but no result is pending");

endmodule

### test/tb_square_spiral_scan_generator_core.sv
// Self-checking testbench for the square spiral scan generator core.
module tb_square_spiral_scan_generator_core;
  import ssg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SIDE_LIMIT   = 64;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned WALK_ITEMS   = 30;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 55;
  localparam int unsigned HOLD_ITEMS   = 40;
  localparam int unsigned SPAN_CAP     = 120;
  localparam int unsigned NUM_ROWS     = 25;

  // Pacing of the two channels; the first four follow the phase index
  typedef enum {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH,
    PACE_HOLD
  } pace_e;

  // One directed stimulus row; result is used only when typed is set
  typedef struct packed {
    logic [CFG_W-1:0] side;
    ssg_in_t          item;
    logic             typed;
    ssg_out_t         result;
  } plan_row_t;

  localparam plan_row_t PLAN [NUM_ROWS] = '{
    // advance straight out of reset, then a walk from reset
    '{7'd1,   '{OP_ADVANCE, 6'd0,  6'd0},  1'b1, '{1'b0, 13'd0,    15'd2, 1'b0}},
    // single cell grid finishes on start, advance after done holds
    '{7'd1,   '{OP_START,   6'd0,  6'd0},  1'b1, '{1'b1, 13'd1,    15'd1, 1'b1}},
    '{7'd1,   '{OP_ADVANCE, 6'd63, 6'd63}, 1'b1, '{1'b0, 13'd0,    15'd1, 1'b1}},
    // start outside the grid
    '{7'd1,   '{OP_START,   6'd63, 6'd63}, 1'b1, '{1'b0, 13'd0,    15'd1, 1'b0}},
    '{7'd1,   '{OP_ADVANCE, 6'd0,  6'd0},  1'b0, '0},
    '{7'd1,   '{OP_START,   6'd0,  6'd63}, 1'b1, '{1'b0, 13'd0,    15'd1, 1'b0}},
    // side zero acts as one
    '{7'd0,   '{OP_START,   6'd0,  6'd0},  1'b1, '{1'b1, 13'd1,    15'd1, 1'b1}},
    // side above the maximum acts as the maximum
    '{7'd127, '{OP_START,   6'd63, 6'd63}, 1'b1, '{1'b1, 13'd4096, 15'd1, 1'b0}},
    '{7'd127, '{OP_ADVANCE, 6'd0,  6'd0},  1'b0, '0},
    '{7'd127, '{OP_ADVANCE, 6'd63, 6'd0},  1'b0, '0},
    '{7'd64,  '{OP_START,   6'd63, 6'd0},  1'b1, '{1'b1, 13'd4033, 15'd1, 1'b0}},
    '{7'd64,  '{OP_ADVANCE, 6'd0,  6'd63}, 1'b0, '0},
    '{7'd64,  '{OP_START,   6'd0,  6'd0},  1'b1, '{1'b1, 13'd1,    15'd1, 1'b0}},
    // full scan of a two by two grid, then an advance after done
    '{7'd2,   '{OP_START,   6'd0,  6'd0},  1'b1, '{1'b1, 13'd1,    15'd1, 1'b0}},
    '{7'd2,   '{OP_ADVANCE, 6'd0,  6'd0},  1'b0, '0},
    '{7'd2,   '{OP_ADVANCE, 6'd0,  6'd0},  1'b0, '0},
    '{7'd2,   '{OP_ADVANCE, 6'd0,  6'd0},  1'b0, '0},
    '{7'd2,   '{OP_ADVANCE, 6'd0,  6'd0},  1'b0, '0},
    '{7'd3,   '{OP_START,   6'd1,  6'd1},  1'b1, '{1'b1, 13'd5,    15'd1, 1'b0}},
    '{7'd3,   '{OP_ADVANCE, 6'd0,  6'd0},  1'b0, '0},
    '{7'd3,   '{OP_ADVANCE, 6'd0,  6'd0},  1'b0, '0},
    // side changed in the middle of a scan
    '{7'd5,   '{OP_ADVANCE, 6'd0,  6'd0},  1'b0, '0},
    '{7'd5,   '{OP_ADVANCE, 6'd0,  6'd0},  1'b0, '0},
    '{7'd4,   '{OP_START,   6'd3,  6'd3},  1'b1, '{1'b1, 13'd16,   15'd1, 1'b0}},
    '{7'd4,   '{OP_ADVANCE, 6'd0,  6'd0},  1'b0, '0}
  };

  localparam logic [CFG_W-1:0] PHASE_SIDE [10] = '{
    7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd8, 7'd64, 7'd127, 7'd0, 7'd6
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  ssg_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  ssg_out_t         out_data_o;

  pace_e       pace = PACE_FREE;
  ssg_out_t    expected_q [$];
  int unsigned mismatches = 0;

  // Predicted walker state and side register
  logic [CFG_W-1:0]   side_reg;
  logic [POS_W-1:0]   pos_row;
  logic [POS_W-1:0]   pos_col;
  logic [LEG_W-1:0]   leg_len;
  logic [LEG_W-1:0]   leg_steps;
  dir_e               heading;
  logic [CELLS_W-1:0] found;
  logic [MOVES_W-1:0] moves;
  logic               done_flag;

  square_spiral_scan_generator_core #(
    .MAX_SIDE(SIDE_LIMIT)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Clamp the programmed side to the usable range
  function automatic int unsigned active_side();
    if (side_reg == '0) return 1;
    if (side_reg > SIDE_LIMIT) return SIDE_LIMIT;
    return side_reg;
  endfunction

  // Advance the predicted walker by one item and return its result
  function automatic ssg_out_t spiral_step(input ssg_in_t it);
    ssg_out_t    res;
    int unsigned n;
    int          r;
    int          c;
    bit          moved;
    n = active_side();
    res = '0;
    moved = 1'b1;
    if (it.operation == OP_START) begin
      pos_row   = POS_W'(it.start_row);
      pos_col   = POS_W'(it.start_col);
      leg_len   = LEG_W'(1);
      leg_steps = '0;
      heading   = DIR_COL_INC;
      found     = '0;
      moves     = MOVES_W'(1);
      done_flag = 1'b0;
    end else if (!done_flag) begin
      case (heading)
        DIR_COL_INC: pos_col = pos_col + 1'b1;
        DIR_ROW_INC: pos_row = pos_row + 1'b1;
        DIR_COL_DEC: pos_col = pos_col - 1'b1;
        default:     pos_row = pos_row - 1'b1;
      endcase
      if (moves < MOVES_MAX) moves = moves + 1'b1;
    end else begin
      moved = 1'b0;
    end
    // Report the cell when the position lies inside the grid
    if (moved) begin
      r = $signed(pos_row);
      c = $signed(pos_col);
      if (r >= 0 && c >= 0 && r < int'(n) && c < int'(n)) begin
        res.cell_valid  = 1'b1;
        res.cell_number = CELLS_W'(r * int'(n) + c + 1);
        if (found < CELLS_MAX) found = found + 1'b1;
        if (found >= n * n) done_flag = 1'b1;
      end
    end
    // Close the leg and turn; every second turn lengthens the leg
    if (moved && it.operation == OP_ADVANCE) begin
      leg_steps = leg_steps + 1'b1;
      if (leg_steps >= leg_len) begin
        leg_steps = '0;
        if (heading[0] && leg_len < LEG_MAX) leg_len = leg_len + 1'b1;
        heading = heading.next();
      end
    end
    res.moves_total = moves;
    res.scan_done   = done_flag;
    return res;
  endfunction

  // Present one item, hold it until the transfer, then queue its result
  task automatic offer(input ssg_in_t it, input bit typed, input ssg_out_t typed_res);
    ssg_out_t pred;
    while ((pace == PACE_SEND_IDLE && $urandom_range(0, 99) < 83) ||
           (pace == PACE_BOTH && $urandom_range(0, 99) < 18)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    pred = spiral_step(it);
    expected_q.insert(expected_q.size(), typed ? typed_res : pred);
  endtask

  // Drain the block, then write the side register
  task automatic set_side(input logic [CFG_W-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    side_reg  = value;
  endtask

  // Random item: a start inside or anywhere, or an advance with junk fields
  task automatic offer_random(input logic op, input bit anywhere);
    ssg_in_t     it;
    int unsigned n;
    n = active_side();
    it.operation = op;
    if (op == OP_START && !anywhere) begin
      it.start_row = 6'($urandom_range(0, n - 1));
      it.start_col = 6'($urandom_range(0, n - 1));
    end else begin
      it.start_row = 6'($urandom_range(0, 63));
      it.start_col = 6'($urandom_range(0, 63));
    end
    offer(it, 1'b0, '0);
  endtask

  // Result side: check each transfer and pace the ready
  initial begin : result_side
    int unsigned held;
    ssg_out_t    want;
    held = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: valid=%0d cell=%0d moves=%0d done=%0d", $realtime,
                   out_data_o.cell_valid, out_data_o.cell_number, out_data_o.moves_total,
                   out_data_o.scan_done);
        end else begin
          want = expected_q.pop_front();
          if (out_data_o !== want) begin
            mismatches++;
            $display("%0t expected valid=%0d cell=%0d moves=%0d done=%0d,",
                     $realtime, want.cell_valid, want.cell_number, want.moves_total,
                     want.scan_done,
                     " actual valid=%0d cell=%0d moves=%0d done=%0d",
                     out_data_o.cell_valid, out_data_o.cell_number,
                     out_data_o.moves_total, out_data_o.scan_done);
          end
        end
      end
      case (pace)
        PACE_HOLD: begin
          if (held < HOLD_CYCLES) begin
            held++;
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
          end
        end
        PACE_RECV_STALL: out_ready_i <= ($urandom_range(0, 99) >= 83);
        PACE_BOTH:       out_ready_i <= ($urandom_range(0, 99) >= 18);
        default:         out_ready_i <= 1'b1;
      endcase
    end
  end

  // Stimulus
  initial begin : stimulus
    ssg_in_t     walk_item;
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    int unsigned span;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    side_reg    = CFG_W'(1);
    pos_row     = '0;
    pos_col     = '0;
    leg_len     = LEG_W'(1);
    leg_steps   = '0;
    heading     = DIR_COL_INC;
    found       = '0;
    moves       = MOVES_W'(1);
    done_flag   = 1'b0;
    walk_item   = '{OP_ADVANCE, 6'd0, 6'd0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; a short walk from reset runs after the first row
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (i == 1) repeat (WALK_ITEMS) offer(walk_item, 1'b0, '0);
      if (PLAN[i].side != side_reg) set_side(PLAN[i].side);
      offer(PLAN[i].item, PLAN[i].typed, PLAN[i].result);
    end

    // Random phases: mostly a start followed by a run of advances
    foreach (PHASE_SIDE[p]) begin
      set_side(PHASE_SIDE[p]);
      pace <= pace_e'(p % 4);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        n = active_side();
        if (pick < 8) begin
          offer_random(OP_START, 1'b0);
          span = 4 * n * n + 4;
          if (span > SPAN_CAP) span = SPAN_CAP;
          span = $urandom_range(1, span);
          repeat (span) offer_random(OP_ADVANCE, 1'b0);
          sent += span + 1;
        end else if (pick == 8) begin
          offer_random(OP_START, 1'b1);
          sent++;
        end else begin
          span = $urandom_range(1, 5);
          repeat (span) offer_random(OP_ADVANCE, 1'b0);
          sent += span;
        end
      end
    end

    // Long receiver hold-off while items keep coming
    set_side(7'd64);
    pace <= PACE_HOLD;
    repeat (HOLD_ITEMS) offer_random(($urandom_range(0, 3) == 0) ? OP_START : OP_ADVANCE, 1'b1);

    // Wait out the last results
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4 * DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("square_spiral_scan_generator_core: match");
    end else begin
      $display("square_spiral_scan_generator_core: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #10_000_000;
    $display("square_spiral_scan_generator_core: mismatch");
    $finish;
  end

endmodule

### square_spiral_scan_generator_core.f
hw/rtl/ssg_pkg.sv
hw/rtl/ssg_walker.sv
hw/rtl/square_spiral_scan_generator_core.sv
test/tb_square_spiral_scan_generator_core.sv
